@@ rtl/bffl_pkg.sv @@
// Shared types and constants of the best-fit free-list allocator.
`default_nettype none
package bffl_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_HEAP_FULL  = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] user_address;
		logic [SIZE_W-1:0] chunk_size;
	} job_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted_address;
		logic [SIZE_W-1:0] granted_size;
		logic              reused;
	} res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef enum logic [1:0] {
		POST_NONE,
		POST_FREE,
		POST_REUSE,
		POST_CARVE
	} post_t;

	typedef struct packed {
		logic  capture;
		logic  scan_init;
		logic  scan_run;
		logic  shift_init;
		logic  shift_run;
		post_t post;
	} ctl_t;

	typedef struct packed {
		logic is_free;
		logic table_full;
		logic table_empty;
		logic scan_done;
		logic found;
		logic shift_done;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/bffl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bffl_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/bffl_ctrl.sv @@
// Controller state machine of the best-fit free-list allocator.
`default_nettype none
module bffl_ctrl
	import bffl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_PICK,
		S_MUL,
		S_CARVE,
		S_SHIFT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_free) begin
					ctl.post = POST_FREE;
					state_d  = S_IDLE;
				end else if (sts.table_empty) begin
					state_d = S_MUL;
				end else begin
					ctl.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (sts.found) begin
					ctl.shift_init = 1'b1;
					state_d        = S_SHIFT;
				end else begin
					state_d = S_CARVE;
				end
			end
			S_MUL: begin
				state_d = S_CARVE;
			end
			S_CARVE: begin
				ctl.post = POST_CARVE;
				state_d  = S_IDLE;
			end
			S_SHIFT: begin
				ctl.shift_run = 1'b1;
				if (sts.shift_done) begin
					ctl.post = POST_REUSE;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (ctl.post != POST_NONE);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");
`endif

endmodule
`default_nettype wire

@@ rtl/bffl_dp.sv @@
// Datapath of the best-fit free-list allocator: free table, scan, compaction, heap top.
`default_nettype none
module bffl_dp
	import bffl_pkg::*;
#(
	parameter int FREE_ENTRIES    = 16,
	parameter int ALIGN_BYTES     = 8,
	parameter int HEADER_BYTES    = 8,
	parameter int MIN_BLOCK_BYTES = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctl_t                 ctl,
	output sts_t                      sts,
	input  wire job_t                 job,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	output res_t                      result
);

	localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
	localparam int HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int Y_W   = SIZE_W + 1;
	localparam int SH    = Y_W + $clog2(ALIGN_BYTES);
	localparam int M_W   = Y_W + 1;
	localparam int P_W   = Y_W + M_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);

	job_t              job_q;
	logic [ADDR_W-1:0] heap_top_q;
	logic [ADDR_W-1:0] heap_limit_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic              issue_q;
	logic              ev_v_s1;
	logic [IDX_W-1:0]  ev_idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  pick_q;
	entry_t            best_q;
	logic [IDX_W-1:0]  shift_k_q;
	logic              wr_v_s1;
	logic [IDX_W-1:0]  wr_idx_s1;
	logic [Y_W-1:0]    q_s1;
	logic [Y_W-1:0]    chunk_s2;
	res_t              result_q;

	entry_t            rd_ent;
	logic [$bits(entry_t)-1:0] rdata;
	logic              hit_ge;
	logic              exact;
	logic              better;
	logic [CNT_W-1:0]  shift_nxt;
	logic              shift_issue;
	logic              table_full;
	logic              push;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [Y_W-1:0]    want;
	logic [Y_W-1:0]    y;
	logic [P_W-1:0]    prod;
	logic [ADDR_W+1:0] new_top;
	logic              fits;

	assign rd_ent      = entry_t'(rdata);
	assign hit_ge      = ev_v_s1 && (rd_ent.size >= job_q.request_size);
	assign exact       = hit_ge && (rd_ent.size == job_q.request_size);
	assign better      = hit_ge && (!found_q || (rd_ent.size < best_q.size));
	assign shift_nxt   = CNT_W'(shift_k_q) + CNT_W'(1);
	assign shift_issue = shift_nxt < count_q;
	assign table_full  = (count_q == CNT_W'(FREE_ENTRIES));
	assign push        = (ctl.post == POST_FREE) && !table_full;

	assign ram_we         = push || wr_v_s1;
	assign ram_waddr      = wr_v_s1 ? wr_idx_s1 : count_q[IDX_W-1:0];
	assign ram_wdata.addr = wr_v_s1 ? rd_ent.addr : job_q.user_address;
	assign ram_wdata.size = wr_v_s1 ? rd_ent.size : job_q.chunk_size;
	assign ram_raddr      = ctl.shift_run ? shift_nxt[IDX_W-1:0] : scan_idx_q;

	bffl_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (FREE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign want = (job_q.request_size < SIZE_W'(MIN_BLOCK_BYTES)) ?
		Y_W'(MIN_BLOCK_BYTES) : {1'b0, job_q.request_size};
	assign y    = want + Y_W'(ALIGN_BYTES - 1);
	assign prod = P_W'(y) * P_W'(RECIP[M_W-1:0]);

	assign new_top = {2'b00, heap_top_q} + (ADDR_W + 2)'(HDR) +
		(ADDR_W + 2)'(chunk_s2);
	assign fits = !chunk_s2[SIZE_W] && (new_top <= {2'b00, heap_limit_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_top_q   <= '0;
			heap_limit_q <= '1;
			count_q      <= '0;
			issue_q      <= 1'b0;
			ev_v_s1      <= 1'b0;
			wr_v_s1      <= 1'b0;
		end else begin
			if (push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.post == POST_REUSE) begin
				count_q <= count_q - CNT_W'(1);
			end
			if ((ctl.post == POST_CARVE) && fits) begin
				heap_top_q <= new_top[ADDR_W-1:0];
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HEAP_START: heap_top_q   <= cfg_data;
					REG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.scan_init) begin
				issue_q <= 1'b1;
			end else if (ctl.scan_run && issue_q && (scan_idx_q == '0)) begin
				issue_q <= 1'b0;
			end
			ev_v_s1 <= ctl.scan_run && issue_q;
			wr_v_s1 <= ctl.shift_run && shift_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			job_q <= job;
		end
		if (ctl.scan_init) begin
			scan_idx_q <= IDX_W'(count_q - CNT_W'(1));
			found_q    <= 1'b0;
		end else begin
			if (ctl.scan_run && issue_q && (scan_idx_q != '0)) begin
				scan_idx_q <= scan_idx_q - IDX_W'(1);
			end
			if (ctl.scan_run && (exact || better)) begin
				found_q <= 1'b1;
				pick_q  <= ev_idx_s1;
				best_q  <= rd_ent;
			end
		end
		ev_idx_s1 <= scan_idx_q;
		if (ctl.shift_init) begin
			shift_k_q <= pick_q;
		end else if (ctl.shift_run && shift_issue) begin
			shift_k_q <= shift_nxt[IDX_W-1:0];
		end
		wr_idx_s1 <= shift_k_q;
		q_s1      <= Y_W'(prod >> SH);
		chunk_s2  <= q_s1 * Y_W'(ALIGN_BYTES);
		case (ctl.post)
			POST_FREE: begin
				result_q <= '{status: (table_full ? ST_TABLE_FULL : ST_OK),
					granted_address: '0, granted_size: '0, reused: 1'b0};
			end
			POST_REUSE: begin
				result_q.status          <= ST_OK;
				result_q.granted_address <= best_q.addr;
				result_q.granted_size    <= best_q.size;
				result_q.reused          <= 1'b1;
			end
			POST_CARVE: begin
				if (fits) begin
					result_q.status          <= ST_OK;
					result_q.granted_address <= heap_top_q + ADDR_W'(HDR);
					result_q.granted_size    <= chunk_s2[SIZE_W-1:0];
					result_q.reused          <= 1'b0;
				end else begin
					result_q <= '{status: ST_HEAP_FULL, granted_address: '0,
						granted_size: '0, reused: 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign result = result_q;

	assign sts.is_free     = (job_q.command == CMD_FREE);
	assign sts.table_full  = table_full;
	assign sts.table_empty = (count_q == '0);
	assign sts.scan_done   = ev_v_s1 && (exact || (ev_idx_s1 == '0));
	assign sts.found       = found_q;
	assign sts.shift_done  = !shift_issue && !wr_v_s1;

`ifndef SYNTHESIS
	a_full_free_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.post == POST_FREE) && table_full |=> count_q == $past(count_q))
		else $error("free into a full table changed the entry count");
	a_heap_full_holds_top: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.post == POST_CARVE) && !fits && !cfg_we |=> heap_top_q == $past(heap_top_q))
		else $error("failed carve moved the heap top");
	a_reuse_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.post == POST_REUSE) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("reused block did not leave the table");
	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		ev_v_s1 |-> CNT_W'(ev_idx_s1) < count_q)
		else $error("scan evaluated an entry beyond the table fill");
`endif

endmodule
`default_nettype wire

@@ rtl/best_fit_free_list_allocator.sv @@
// Top level of the best-fit free-list allocator with bump pointer.
// Free: done is registered from the decode state; an allocate with an empty table goes
// through decode, multiply and carve. Allocate with n entries: a scan of up to n entries,
// then a carve or compaction above the reused entry; the RAM has one read and one write port.
// One item at a time; the next start beat may come in the cycle of the done strobe.
// Reset empties the table, clears heap top to 0 and sets the heap limit to all ones.
`default_nettype none
module best_fit_free_list_allocator
	import bffl_pkg::*;
#(
	parameter int FREE_ENTRIES    = 16,
	parameter int ALIGN_BYTES     = 8,
	parameter int HEADER_BYTES    = 8,
	parameter int MIN_BLOCK_BYTES = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire job_t                 job,
	output logic                      done,
	output res_t                      result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data
);

	ctl_t ctl;
	sts_t sts;

	bffl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.ctl    (ctl)
	);

	bffl_dp #(
		.FREE_ENTRIES    (FREE_ENTRIES),
		.ALIGN_BYTES     (ALIGN_BYTES),
		.HEADER_BYTES    (HEADER_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.job       (job),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the best-fit free-list allocator: directed table, then random phases.
module testbench;
	import bffl_pkg::*;

	localparam int FREE_ENTRIES     = 16;
	localparam int ALIGN_BYTES      = 8;
	localparam int HEADER_BYTES     = 8;
	localparam int MIN_BLOCK_BYTES  = 8;
	localparam int HDR_SPAN         = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int DRAIN_CYCLES     = 2 * FREE_ENTRIES + 8;
	localparam int ITEMS_PER_PHASE  = 325;
	localparam logic CMD_ALLOC      = ~CMD_FREE;

	typedef struct {
		job_t item;
		bit   pinned;
		res_t want;
	} step_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	job_t                 job;
	logic                 done;
	res_t                 result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	logic [ADDR_W-1:0] heap_start_q;
	logic [ADDR_W-1:0] heap_limit_q;
	logic [ADDR_W-1:0] heap_top_q;
	entry_t            free_table[$];
	entry_t            live_blocks[$];
	res_t              expected_q[$];
	step_row_t         directed_rows[$];
	bit                pinned_valid;
	res_t              pinned_res;
	int                error_count;

	best_fit_free_list_allocator #(
		.FREE_ENTRIES(FREE_ENTRIES),
		.ALIGN_BYTES(ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.job(job),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic res_t allocator_outcome(input job_t j);
		res_t              r;
		int                pick;
		logic [SIZE_W-1:0] best;
		logic [63:0]       want;
		logic [63:0]       chunk;
		logic [63:0]       new_top;
		r = '0;
		if (j.command == CMD_FREE) begin
			if (free_table.size() >= FREE_ENTRIES)
				r.status = ST_TABLE_FULL;
			else
				free_table.push_back('{addr: j.user_address - 32'(HDR_SPAN), size: j.chunk_size});
			return r;
		end
		pick = -1;
		best = '0;
		for (int i = free_table.size() - 1; i >= 0; i--) begin
			if (free_table[i].size >= j.request_size) begin
				if (free_table[i].size == j.request_size) begin
					pick = i;
					break;
				end
				if (pick < 0 || free_table[i].size < best) begin
					pick = i;
					best = free_table[i].size;
				end
			end
		end
		if (pick >= 0) begin
			r.status          = ST_OK;
			r.granted_address = free_table[pick].addr + 32'(HDR_SPAN);
			r.granted_size    = free_table[pick].size;
			r.reused          = 1'b1;
			free_table.delete(pick);
			return r;
		end
		want    = (j.request_size < MIN_BLOCK_BYTES) ? 64'(MIN_BLOCK_BYTES) : 64'(j.request_size);
		chunk   = ((want + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES)) * 64'(ALIGN_BYTES);
		new_top = 64'(heap_top_q) + 64'(HDR_SPAN) + chunk;
		if (chunk > 64'hFF_FFFF || new_top > 64'(heap_limit_q)) begin
			r.status = ST_HEAP_FULL;
			return r;
		end
		r.status          = ST_OK;
		r.granted_address = heap_top_q + 32'(HDR_SPAN);
		r.granted_size    = chunk[SIZE_W-1:0];
		heap_top_q        = new_top[ADDR_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		error_count++;
		if (error_count <= 100)
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
	endtask

	task automatic compare_result(input res_t got, input res_t want);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.granted_address !== want.granted_address)
			report_mismatch("granted_address", got.granted_address, want.granted_address);
		if (got.granted_size !== want.granted_size)
			report_mismatch("granted_size", 32'(got.granted_size), 32'(want.granted_size));
		if (got.reused !== want.reused)
			report_mismatch("reused", 32'(got.reused), 32'(want.reused));
	endtask

	always @(posedge clk) begin
		res_t predicted;
		if (done === 1'b1) begin
			if (expected_q.size() == 0)
				report_mismatch("beat with nothing outstanding", result.granted_address, '0);
			else
				compare_result(result, expected_q.pop_front());
		end
		if (start && !busy) begin
			predicted = allocator_outcome(job);
			if (job.command == CMD_ALLOC && predicted.status == ST_OK)
				live_blocks.push_back('{addr: predicted.granted_address,
					size: predicted.granted_size});
			expected_q.push_back(pinned_valid ? pinned_res : predicted);
		end
	end

	task automatic add_row(input job_t item, input bit pinned, input res_t want);
		step_row_t row;
		row.item   = item;
		row.pinned = pinned;
		row.want   = want;
		directed_rows.push_back(row);
	endtask

	// Called at a falling edge; returns at the falling edge after the accepting beat.
	task automatic send_item(input job_t item, input bit pin, input res_t pin_res,
			input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat (($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6))
				@(negedge clk);
		end
		pinned_valid = pin;
		pinned_res   = pin_res;
		start <= 1'b1;
		job   <= item;
		while (busy)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (expected_q.size() != 0);
	endtask

	task automatic set_heap(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEAP_START;
		cfg_data  <= base;
		@(negedge clk);
		cfg_index <= REG_HEAP_LIMIT;
		cfg_data  <= limit;
		@(negedge clk);
		cfg_we <= 1'b0;
		heap_start_q = base;
		heap_top_q   = base;
		heap_limit_q = limit;
	endtask

	function automatic job_t make_item(input int free_pct);
		job_t j;
		int   k;
		j.command      = CMD_ALLOC;
		j.request_size = SIZE_W'($urandom);
		j.user_address = $urandom;
		j.chunk_size   = SIZE_W'($urandom);
		if ($urandom_range(99) < free_pct) begin
			j.command = CMD_FREE;
			// return a live block most of the time, else free noise
			if (live_blocks.size() != 0 && $urandom_range(9) != 0) begin
				k              = $urandom_range(live_blocks.size() - 1);
				j.user_address = live_blocks[k].addr;
				j.chunk_size   = live_blocks[k].size;
				live_blocks.delete(k);
			end
		end else begin
			case ($urandom_range(9))
				0: ;
				1, 2, 3: begin
					if (free_table.size() != 0)
						j.request_size = free_table[$urandom_range(free_table.size() - 1)].size;
					else
						j.request_size = SIZE_W'($urandom_range(64));
				end
				default: j.request_size = SIZE_W'($urandom_range(200));
			endcase
		end
		return j;
	endfunction

	task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit,
			input int idle_pct, input int free_pct);
		wait_idle();
		set_heap(base, limit);
		repeat (ITEMS_PER_PHASE) begin
			if ($urandom_range(99) == 0)
				wait_idle();
			send_item(make_item(free_pct), 1'b0, '0, idle_pct);
		end
	endtask

	initial begin
		error_count  = 0;
		pinned_valid = 1'b0;
		pinned_res   = '0;
		arst_n       = 1'b0;
		start        = 1'b0;
		job          = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_HEAP_START;
		cfg_data     = '0;
		heap_start_q = '0;
		heap_limit_q = '1;
		heap_top_q   = '0;

		add_row('{CMD_ALLOC, 24'd0, 32'h0, 24'h0}, 1'b1, '{ST_OK, 32'h8, 24'h8, 1'b0});
		add_row('{CMD_ALLOC, 24'hFF_FFFF, 32'h0, 24'h0}, 1'b1, '{ST_HEAP_FULL, 32'h0, 24'h0, 1'b0});
		add_row('{CMD_ALLOC, 24'hFF_FFF8, 32'hFFFF_FFFF, 24'hFF_FFFF}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd13, 32'h0, 24'h0}, 1'b0, '0);
		add_row('{CMD_FREE, 24'h0, 32'h8, 24'h8}, 1'b1, '{ST_OK, 32'h0, 24'h0, 1'b0});
		add_row('{CMD_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF}, 1'b1,
			'{ST_OK, 32'h0, 24'h0, 1'b0});
		add_row('{CMD_FREE, 24'h0, 32'h4, 24'd40}, 1'b0, '0);
		add_row('{CMD_FREE, 24'h0, 32'h100, 24'd24}, 1'b0, '0);
		add_row('{CMD_FREE, 24'h0, 32'h200, 24'd40}, 1'b0, '0);
		add_row('{CMD_FREE, 24'h0, 32'h0, 24'd0}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd40, 32'h0, 24'h0}, 1'b1, '{ST_OK, 32'h200, 24'd40, 1'b1});
		add_row('{CMD_ALLOC, 24'd30, 32'h0, 24'h0}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd0, 32'h0, 24'h0}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd9, 32'h0, 24'h0}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd20, 32'h0, 24'h0}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd8, 32'h0, 24'h0}, 1'b0, '0);
		add_row('{CMD_ALLOC, 24'd0, 32'h0, 24'h0}, 1'b0, '0);

		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want, 0);

		run_phase(32'h0000_1000, 32'hFFFF_FFFF, 0, 45);
		run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 66, 45);
		run_phase(32'h0010_0000, 32'h0010_0800, 13, 40);
		run_phase(32'h0000_0000, 32'h0000_0000, 66, 60);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13, 50);
		run_phase(32'h8000_0000, 32'hFFFF_FFFF, 0, 50);

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ best_fit_free_list_allocator.f @@
rtl/bffl_pkg.sv
rtl/bffl_ram.sv
rtl/bffl_ctrl.sv
rtl/bffl_dp.sv
rtl/best_fit_free_list_allocator.sv
tb/sv/testbench.sv
